// ===== rtl/core/iat_pkg.sv =====
`timescale 1ns / 1ps

package iat_pkg;

    localparam int DEPTH_DEF       = 256;
    localparam int ENTRY_WIDTH_DEF = 32;

    typedef enum logic [3:0] {
        OP_READ    = 4'd0,
        OP_WRITE   = 4'd1,
        OP_APPEND  = 4'd2,
        OP_INSERT  = 4'd3,
        OP_PREPEND = 4'd4,
        OP_DELETE  = 4'd5,
        OP_DROP    = 4'd6,
        OP_FIND    = 4'd7,
        OP_SEARCH  = 4'd8
    } op_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2,
        ST_EMPTY = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_FIND,
        S_SEARCH,
        S_DONE
    } fsm_t;

    // register indexes (byte address bit 2)
    localparam logic REG_LIMIT  = 1'b0;
    localparam logic REG_SIGNED = 1'b1;

    // per-cycle command broadcast to every cell
    typedef struct packed {
        logic ins;   // shift up from pos, load pos
        logic del;   // shift down from pos
        logic wr;    // load pos only
    } cell_ctl_t;

endpackage

// ===== rtl/core/indexed_array_table.sv =====
`timescale 1ns / 1ps

// Channel   Dir  Handshake          Payload
// s_        in   s_tvalid/s_tready  operation, position, entry_value
// m_        out  m_tvalid/m_tready  read_value, found, found_position, status, fill_count
// apb       in   psel/penable       table_limit @0x0, compare_signed @0x4
//
// One item at a time. Read, write, append, insert, prepend, delete and drop
// pass through accept, execute and deliver steps; find adds a find step
// between execute and deliver (a registered match broadcast across the cell
// row, then a priority encode); search adds a probe step per probe, up to
// log2(DEPTH)+1 probes, each one read of the cell row and one compare. Shifts
// move every cell at once. Reset (aresetn low, synchronous) empties the table;
// entry cells are not cleared. A stalled result holds the block in its deliver step.

module indexed_array_table #(
    parameter int DEPTH       = iat_pkg::DEPTH_DEF,
    parameter int ENTRY_WIDTH = iat_pkg::ENTRY_WIDTH_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    // [3:0] operation, [11:4] position, [43:12] entry_value
    input  logic [47:0] s_tdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    // [31:0] read_value, [32] found, [40:33] found_position,
    // [42:41] status, [51:43] fill_count
    output logic [55:0] m_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import iat_pkg::*;

    localparam int EW   = ENTRY_WIDTH;
    localparam int IW   = $clog2(DEPTH);
    localparam int CW   = $clog2(DEPTH + 1);
    localparam int CMPW = (CW > 9) ? CW : 9;
    localparam logic [CMPW-1:0] DEPTH_C = CMPW'(DEPTH);
    localparam logic [CMPW-1:0] ONE_C   = CMPW'(1);

    // configuration
    logic [8:0] limit_reg;
    logic       signed_reg;

    assign pready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            limit_reg  <= 9'd256;
            signed_reg <= 1'b0;
        end else if (psel && penable && pwrite && pready) begin
            unique case (paddr[2])
                REG_LIMIT:  limit_reg  <= pwdata[8:0];
                REG_SIGNED: signed_reg <= pwdata[0];
                default:    limit_reg  <= limit_reg;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_LIMIT:  prdata = {23'd0, limit_reg};
            REG_SIGNED: prdata = {31'd0, signed_reg};
            default:    prdata = 32'd0;
        endcase
    end

    // usable limit, clipped to the built depth
    logic [CMPW-1:0] lim_ext;
    assign lim_ext = (CMPW'(limit_reg) > DEPTH_C) ? DEPTH_C : CMPW'(limit_reg);

    // control and item registers
    fsm_t            state_reg, state_next;
    logic [3:0]      op_reg;
    logic [CMPW-1:0] pos_reg;
    logic [EW-1:0]   val_reg;
    logic [CMPW-1:0] count_reg, count_next;
    logic [CMPW-1:0] lo_reg, lo_next, hi_reg, hi_next;
    logic [31:0]     rd_reg, rd_next;
    logic            hit_reg, hit_next;
    logic [CMPW-1:0] hpos_reg, hpos_next;
    logic [1:0]      stat_reg, stat_next;
    logic            m_valid_reg, m_valid_next;
    logic [55:0]     m_data_reg;

    logic [63:0]     in_val_wide;
    assign in_val_wide = 64'(s_tdata[43:12]);

    // cell row
    cell_ctl_t       ctl;
    logic [CMPW-1:0] cell_pos;
    logic [EW-1:0]   cell_val [DEPTH];
    logic [DEPTH-1:0] cell_match;

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic [EW-1:0] prev_v, next_v;
        if (g == 0) begin : g_first
            assign prev_v = '0;
        end else begin : g_prev
            assign prev_v = cell_val[g-1];
        end
        if (g == DEPTH - 1) begin : g_last
            assign next_v = '0;
        end else begin : g_next
            assign next_v = cell_val[g+1];
        end
        iat_cell #(.EW(EW), .CMPW(CMPW), .INDEX(g)) u_cell (
            .aclk       (aclk),
            .ctl        (ctl),
            .pos        (cell_pos),
            .wr_value   (val_reg),
            .prev_value (prev_v),
            .next_value (next_v),
            .key        (val_reg),
            .value      (cell_val[g]),
            .match      (cell_match[g])
        );
    end

    // first match below count
    logic            find_hit;
    logic [CMPW-1:0] find_pos;
    always_comb begin
        find_hit = 1'b0;
        find_pos = '0;
        for (int i = DEPTH - 1; i >= 0; i--) begin
            if (cell_match[i] && CMPW'(i) < count_reg) begin
                find_hit = 1'b1;
                find_pos = CMPW'(i);
            end
        end
    end

    // search probe
    logic [CMPW-1:0] mid;
    logic [EW-1:0]   probe, key_x, probe_x;
    logic [EW-1:0]   sign_flip;
    assign mid       = lo_reg + ((hi_reg - lo_reg) >> 1);
    assign probe     = cell_val[mid[IW-1:0]];
    assign sign_flip = {signed_reg, {(EW-1){1'b0}}};
    assign key_x     = val_reg ^ sign_flip;
    assign probe_x   = probe ^ sign_flip;

    logic [EW-1:0]   pos_entry;
    logic [63:0]     pos_entry_wide;
    assign pos_entry      = cell_val[pos_reg[IW-1:0]];
    assign pos_entry_wide = 64'(pos_entry);

    logic [CMPW-1:0] ins_pos;

    assign s_tready = (state_reg == S_IDLE);

    always_comb begin
        state_next   = state_reg;
        count_next   = count_reg;
        lo_next      = lo_reg;
        hi_next      = hi_reg;
        rd_next      = rd_reg;
        hit_next     = hit_reg;
        hpos_next    = hpos_reg;
        stat_next    = stat_reg;
        m_valid_next = m_valid_reg;
        ctl          = '0;
        cell_pos     = pos_reg;
        ins_pos      = pos_reg;

        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    state_next = S_EXEC;
                    rd_next    = '0;
                    hit_next   = 1'b0;
                    hpos_next  = '0;
                    stat_next  = ST_OK;
                end
            end
            S_EXEC: begin
                state_next = S_DONE;
                if (op_reg == OP_APPEND) begin
                    ins_pos = count_reg;
                end else if (op_reg == OP_PREPEND) begin
                    ins_pos = '0;
                end
                unique case (op_reg)
                    OP_READ: begin
                        if (pos_reg >= count_reg) begin
                            stat_next = ST_RANGE;
                        end else begin
                            rd_next = pos_entry_wide[31:0];
                        end
                    end
                    OP_WRITE: begin
                        if (pos_reg > count_reg || pos_reg >= lim_ext) begin
                            stat_next = ST_RANGE;
                        end else begin
                            ctl.wr = 1'b1;
                            if (pos_reg == count_reg) begin
                                count_next = count_reg + ONE_C;
                            end
                        end
                    end
                    OP_APPEND, OP_INSERT, OP_PREPEND: begin
                        cell_pos = ins_pos;
                        if (ins_pos > count_reg) begin
                            stat_next = ST_RANGE;
                        end else if (count_reg >= lim_ext) begin
                            stat_next = ST_FULL;
                        end else begin
                            ctl.ins    = 1'b1;
                            count_next = count_reg + ONE_C;
                        end
                    end
                    OP_DELETE: begin
                        if (count_reg == '0) begin
                            stat_next = ST_EMPTY;
                        end else if (pos_reg >= count_reg) begin
                            stat_next = ST_RANGE;
                        end else begin
                            ctl.del    = 1'b1;
                            count_next = count_reg - ONE_C;
                        end
                    end
                    OP_DROP: begin
                        if (count_reg == '0) begin
                            stat_next = ST_EMPTY;
                        end else begin
                            count_next = count_reg - ONE_C;
                        end
                    end
                    OP_FIND: begin
                        state_next = S_FIND;
                    end
                    OP_SEARCH: begin
                        if (count_reg != '0) begin
                            lo_next    = '0;
                            hi_next    = count_reg - ONE_C;
                            state_next = S_SEARCH;
                        end
                    end
                    default: begin
                        stat_next = ST_OK;
                    end
                endcase
            end
            S_FIND: begin
                hit_next   = find_hit;
                hpos_next  = find_pos;
                state_next = S_DONE;
            end
            S_SEARCH: begin
                if (key_x == probe_x) begin
                    hit_next   = 1'b1;
                    hpos_next  = mid;
                    state_next = S_DONE;
                end else if (key_x < probe_x) begin
                    if (mid == lo_reg) begin
                        state_next = S_DONE;
                    end else begin
                        hi_next = mid - ONE_C;
                    end
                end else begin
                    if (mid == hi_reg) begin
                        state_next = S_DONE;
                    end else begin
                        lo_next = mid + ONE_C;
                    end
                end
            end
            S_DONE: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        lo_reg   <= lo_next;
        hi_reg   <= hi_next;
        rd_reg   <= rd_next;
        hit_reg  <= hit_next;
        hpos_reg <= hpos_next;
        stat_reg <= stat_next;
        if (state_reg == S_IDLE && s_tvalid) begin
            op_reg  <= s_tdata[3:0];
            pos_reg <= CMPW'(s_tdata[11:4]);
            val_reg <= in_val_wide[EW-1:0];
        end
        if (state_reg == S_DONE && (!m_valid_reg || m_tready)) begin
            m_data_reg <= {4'd0, count_reg[8:0], stat_reg, hpos_reg[7:0],
                           hit_reg, rd_reg};
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule

// ===== rtl/core/iat_cell.sv =====
`timescale 1ns / 1ps

module iat_cell #(
    parameter int EW    = 32,
    parameter int CMPW  = 9,
    parameter int INDEX = 0
) (
    input  logic                  aclk,
    input  iat_pkg::cell_ctl_t    ctl,
    input  logic [CMPW-1:0]       pos,
    input  logic [EW-1:0]         wr_value,
    input  logic [EW-1:0]         prev_value,
    input  logic [EW-1:0]         next_value,
    input  logic [EW-1:0]         key,
    output logic [EW-1:0]         value,
    output logic                  match
);
    import iat_pkg::*;

    localparam logic [CMPW-1:0] MY_IDX = CMPW'(INDEX);

    logic [EW-1:0] value_reg;
    logic [EW-1:0] value_next;
    logic          match_reg;

    always_comb begin
        value_next = value_reg;
        if (ctl.wr && pos == MY_IDX) begin
            value_next = wr_value;
        end else if (ctl.ins) begin
            if (pos == MY_IDX) begin
                value_next = wr_value;
            end else if (MY_IDX > pos) begin
                value_next = prev_value;
            end
        end else if (ctl.del && MY_IDX >= pos) begin
            value_next = next_value;
        end
    end

    always_ff @(posedge aclk) begin
        value_reg <= value_next;
        match_reg <= (value_reg == key);
    end

    assign value = value_reg;
    assign match = match_reg;

endmodule

// ===== bench/indexed_array_table_test.sv =====
`timescale 1ns / 1ps

module indexed_array_table_test;
    import iat_pkg::*;

    // last member sits in the lowest bits
    typedef struct packed {
        logic [31:0] entry_value;
        logic [7:0]  position;
        logic [3:0]  operation;
    } table_op_t;

    typedef struct packed {
        logic [8:0]  fill_count;
        logic [1:0]  status;
        logic [7:0]  found_position;
        logic        found;
        logic [31:0] read_value;
    } table_reply_t;

    localparam int  CYCLE_LIMIT = 400000;
    localparam int  HOLD_CYCLES = 300;
    localparam int  DRAIN_CYCLES = 40;

    logic        aclk;
    logic        aresetn;
    logic [47:0] s_tdata;
    logic        s_tvalid;
    logic        s_tready;
    logic [55:0] m_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    indexed_array_table DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_tdata(s_tdata), .s_tvalid(s_tvalid), .s_tready(s_tready),
        .m_tdata(m_tdata), .m_tvalid(m_tvalid), .m_tready(m_tready),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    // shadow copy of the table used to predict replies
    logic [31:0] shadow_entries [256];
    int          shadow_count;
    int          shadow_limit;
    logic        shadow_signed;

    table_op_t    pending_ops[$];
    table_reply_t expected_replies[$];
    int           errors;
    int           cycle_count;
    int           replies_seen;
    int           ops_sent;
    bit           hold_off;
    bit           stim_paused;

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // cycle counter doubles as the watchdog
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    function automatic logic key_less(logic [31:0] a, logic [31:0] b);
        if (shadow_signed)
            return $signed(a) < $signed(b);
        return a < b;
    endfunction

    // predicts the reply and updates the shadow table
    function automatic table_reply_t table_apply(table_op_t op);
        table_reply_t r;
        int pos;
        int lim;
        int lo;
        int hi;
        int mid;
        r = '0;
        pos = op.position;
        lim = shadow_limit > 256 ? 256 : shadow_limit;
        case (op.operation)
            OP_READ: begin
                if (pos >= shadow_count) r.status = ST_RANGE;
                else r.read_value = shadow_entries[pos];
            end
            OP_WRITE: begin
                if (pos > shadow_count || pos >= lim) r.status = ST_RANGE;
                else begin
                    shadow_entries[pos] = op.entry_value;
                    if (pos == shadow_count) shadow_count++;
                end
            end
            OP_APPEND, OP_INSERT, OP_PREPEND: begin
                if (op.operation == OP_APPEND) pos = shadow_count;
                else if (op.operation == OP_PREPEND) pos = 0;
                if (pos > shadow_count) r.status = ST_RANGE;
                else if (shadow_count >= lim) r.status = ST_FULL;
                else begin
                    for (int i = shadow_count; i > pos; i--)
                        shadow_entries[i] = shadow_entries[i-1];
                    shadow_entries[pos] = op.entry_value;
                    shadow_count++;
                end
            end
            OP_DELETE: begin
                if (shadow_count == 0) r.status = ST_EMPTY;
                else if (pos >= shadow_count) r.status = ST_RANGE;
                else begin
                    for (int i = pos; i + 1 < shadow_count; i++)
                        shadow_entries[i] = shadow_entries[i+1];
                    shadow_count--;
                end
            end
            OP_DROP: begin
                if (shadow_count == 0) r.status = ST_EMPTY;
                else shadow_count--;
            end
            OP_FIND: begin
                for (int i = 0; i < shadow_count; i++) begin
                    if (!r.found && shadow_entries[i] == op.entry_value) begin
                        r.found = 1'b1;
                        r.found_position = i[7:0];
                    end
                end
            end
            OP_SEARCH: begin
                // midpoint search; stops at first equal probe
                if (shadow_count > 0) begin
                    lo = 0;
                    hi = shadow_count - 1;
                    while (lo >= 0) begin
                        mid = lo + (hi - lo) / 2;
                        if (shadow_entries[mid] == op.entry_value) begin
                            r.found = 1'b1;
                            r.found_position = mid[7:0];
                            lo = -1;
                        end else if (key_less(op.entry_value, shadow_entries[mid])) begin
                            if (mid == lo) lo = -1;
                            else hi = mid - 1;
                        end else begin
                            if (mid == hi) lo = -1;
                            else lo = mid + 1;
                        end
                    end
                end
            end
            default: ;
        endcase
        r.fill_count = shadow_count[8:0];
        return r;
    endfunction

    // driver: bursts of offers separated by random gaps
    int burst_left;
    int gap_left;
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid   <= 1'b0;
            s_tdata    <= '0;
            burst_left <= 0;
            gap_left   <= 0;
        end else begin
            if (s_tvalid && s_tready) begin
                expected_replies.push_back(table_apply(table_op_t'(s_tdata[43:0])));
                ops_sent++;
            end
            if (!s_tvalid || s_tready) begin
                if (gap_left > 0) begin
                    gap_left <= gap_left - 1;
                    s_tvalid <= 1'b0;
                end else if (pending_ops.size() > 0 && !stim_paused) begin
                    s_tdata  <= {4'b0, pending_ops.pop_front()};
                    s_tvalid <= 1'b1;
                    if (burst_left <= 1) begin
                        burst_left <= $urandom_range(1, 20);
                        gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
                    end else begin
                        burst_left <= burst_left - 1;
                    end
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // receiver stall pattern, with a long hold-off when requested
    int hold_left;
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready  <= 1'b0;
            hold_left <= 0;
        end else if (hold_off && hold_left == 0) begin
            hold_left <= HOLD_CYCLES;
            m_tready  <= 1'b0;
        end else if (hold_left > 1) begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end else begin
            if (hold_left == 1) hold_left <= -1;
            if (!hold_off && hold_left < 0) hold_left <= 0;
            case ((cycle_count / 200) % 3)
                0: m_tready <= 1'b1;
                1: m_tready <= ($urandom_range(0, 3) != 0);
                default: m_tready <= ($urandom_range(0, 2) == 0);
            endcase
        end
    end

    // monitor: compare each reply with the oldest prediction
    always @(posedge aclk) begin
        table_reply_t got;
        table_reply_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got = table_reply_t'(m_tdata[51:0]);
            replies_seen++;
            if (expected_replies.size() == 0) begin
                $display("%0t: unexpected reply %h", $realtime, got);
                errors++;
            end else begin
                want = expected_replies.pop_front();
                if (got.read_value !== want.read_value) begin
                    $display("%0t: read_value exp %h got %h", $realtime,
                             want.read_value, got.read_value);
                    errors++;
                end
                if (got.found !== want.found) begin
                    $display("%0t: found exp %b got %b", $realtime, want.found, got.found);
                    errors++;
                end
                if (got.found_position !== want.found_position) begin
                    $display("%0t: found_position exp %0d got %0d", $realtime,
                             want.found_position, got.found_position);
                    errors++;
                end
                if (got.status !== want.status) begin
                    $display("%0t: status exp %0d got %0d", $realtime, want.status, got.status);
                    errors++;
                end
                if (got.fill_count !== want.fill_count) begin
                    $display("%0t: fill_count exp %0d got %0d", $realtime,
                             want.fill_count, got.fill_count);
                    errors++;
                end
            end
        end
    end

    task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // config only while idle: queue drained plus some settle cycles
    task automatic set_config(input int limit, input logic signed_cmp);
        wait (pending_ops.size() == 0 && !s_tvalid && expected_replies.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        apb_write(3'd0 + {REG_LIMIT, 2'b00}, limit);
        apb_write({REG_SIGNED, 2'b00}, {31'b0, signed_cmp});
        shadow_limit  = limit;
        shadow_signed = signed_cmp;
    endtask

    function automatic table_op_t make_op(logic [3:0] op, int pos, logic [31:0] val);
        table_op_t t;
        t.operation   = op;
        t.position    = pos[7:0];
        t.entry_value = val;
        return t;
    endfunction

    // random value biased toward a small key set so finds hit
    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 3))
            0: return $urandom();
            1: return 32'h8000_0000 + $urandom_range(0, 7) - 4;
            default: return $urandom_range(0, 15);
        endcase
    endfunction

    // mostly legal positions, sometimes past the fill count
    function automatic table_op_t random_op(int est);
        logic [3:0] op;
        int pos;
        op = $urandom_range(0, 19) == 0 ? 4'($urandom_range(9, 15))
                                         : 4'($urandom_range(0, 8));
        if ($urandom_range(0, 7) == 0) pos = $urandom_range(0, 255);
        else pos = $urandom_range(0, est + 1);
        return make_op(op, pos, pick_value());
    endfunction

    initial begin
        int est;
        logic [31:0] v;
        aresetn = 1'b0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        errors = 0; cycle_count = 0; replies_seen = 0; ops_sent = 0;
        hold_off = 1'b0; stim_paused = 1'b0;
        shadow_count = 0; shadow_limit = 256; shadow_signed = 1'b0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: empty-table errors, extremes, every operation
        set_config(4, 1'b0);
        pending_ops.push_back(make_op(OP_READ, 0, 0));
        pending_ops.push_back(make_op(OP_DELETE, 0, 0));
        pending_ops.push_back(make_op(OP_DROP, 0, 0));
        pending_ops.push_back(make_op(OP_FIND, 0, 5));
        pending_ops.push_back(make_op(OP_SEARCH, 0, 5));
        pending_ops.push_back(make_op(OP_WRITE, 1, 9));
        pending_ops.push_back(make_op(OP_WRITE, 0, 32'hFFFF_FFFF));
        pending_ops.push_back(make_op(OP_PREPEND, 0, 32'h0));
        pending_ops.push_back(make_op(OP_INSERT, 1, 32'h8000_0000));
        pending_ops.push_back(make_op(OP_APPEND, 0, 32'h7FFF_FFFF));
        pending_ops.push_back(make_op(OP_APPEND, 0, 1));
        pending_ops.push_back(make_op(OP_INSERT, 5, 1));
        pending_ops.push_back(make_op(OP_WRITE, 4, 1));
        pending_ops.push_back(make_op(OP_READ, 3, 0));
        pending_ops.push_back(make_op(OP_READ, 255, 0));
        pending_ops.push_back(make_op(OP_FIND, 0, 32'h7FFF_FFFF));
        pending_ops.push_back(make_op(OP_SEARCH, 0, 32'hFFFF_FFFF));
        pending_ops.push_back(make_op(4'd15, 8'hFF, 32'hFFFF_FFFF));
        pending_ops.push_back(make_op(OP_DELETE, 4, 0));
        pending_ops.push_back(make_op(OP_DELETE, 0, 0));
        // table now holds 0x8000_0000, 0xFFFF_FFFF, 0x7FFF_FFFF - search path, unsigned then signed
        pending_ops.push_back(make_op(OP_SEARCH, 0, 1));

        set_config(4, 1'b1);
        pending_ops.push_back(make_op(OP_SEARCH, 0, 32'h8000_0000));
        pending_ops.push_back(make_op(OP_SEARCH, 0, 32'h7FFF_FFFF));
        set_config(1, 1'b1);
        pending_ops.push_back(make_op(OP_APPEND, 0, 3));
        pending_ops.push_back(make_op(OP_READ, 2, 0));
        set_config(0, 1'b0);
        pending_ops.push_back(make_op(OP_PREPEND, 0, 3));

        // random phases under several settings
        for (int phase = 0; phase < 8; phase++) begin
            case (phase)
                0: set_config(256, 1'b0);
                1: set_config(16, 1'b1);
                2: set_config(2, 1'b0);
                3: set_config($urandom_range(1, 40), 1'b1);
                4: set_config(256, 1'b1);
                5: set_config(511, 1'b0);
                6: set_config(1, 1'b0);
                default: set_config($urandom_range(3, 30), $urandom_range(0, 1));
            endcase
            est = shadow_count;
            // append a run of mixed-sign values, then searches; the fill is not kept sorted
            if (phase == 1 || phase == 4) begin
                pending_ops.push_back(make_op(OP_DROP, 0, 0));
                for (int k = 0; k < 12; k++) begin
                    v = $urandom_range(0, 1) ? 32'h8000_0000 + k * 3 : k * 7;
                    pending_ops.push_back(make_op(OP_APPEND, 0, v));
                end
                for (int k = 0; k < 20; k++)
                    pending_ops.push_back(make_op(OP_SEARCH, 0, pick_value()));
            end
            for (int k = 0; k < 100; k++) begin
                pending_ops.push_back(random_op(est));
                est = est + 1 > 40 ? 20 : est + ($urandom_range(0, 2) == 0 ? -1 : 1);
                if (est < 0) est = 0;
            end
            // receiver holds off while the sender keeps offering
            if (phase == 2) begin
                hold_off = 1'b1;
                repeat (HOLD_CYCLES + 20) @(posedge aclk);
                hold_off = 1'b0;
            end
        end

        wait (pending_ops.size() == 0 && !s_tvalid && expected_replies.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        $display("Sent %0d items over several limit and sign settings; %0d replies checked.",
                 ops_sent, replies_seen);
        if (errors == 0 && expected_replies.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/core/iat_pkg.sv
rtl/core/iat_cell.sv
rtl/core/indexed_array_table.sv
bench/indexed_array_table_test.sv
